@@ rtl/sprite_xor_blitter_with_scroll_top_defines.svh @@
// Assertion macros for the sprite blitter top level.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef SPRITE_XOR_BLITTER_WITH_SCROLL_TOP_DEFINES_SVH
`define SPRITE_XOR_BLITTER_WITH_SCROLL_TOP_DEFINES_SVH

// same-cycle implication
`define SXB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SXB_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sxb_pkg.sv @@
// Shared types, codes and helpers of the sprite blitter.
// No dependencies.
`timescale 1ns / 1ps

package sxb_pkg;

  localparam int unsigned ColMaxW    = 7;
  localparam int unsigned ScrollCols = 4;
  localparam logic [4:0]  FlagMax    = 5'd31;

  typedef enum logic [2:0] {
    OP_SPRITE       = 3'd0,
    OP_SCROLL_UP    = 3'd1,
    OP_SCROLL_DOWN  = 3'd2,
    OP_SCROLL_LEFT  = 3'd3,
    OP_SCROLL_RIGHT = 3'd4
  } opcode_e;

  typedef struct packed {
    logic [ColMaxW-1:0] col;
    logic [7:0]         left_byte;
    logic [7:0]         right_byte;
    logic               wide;
    logic               wrap;
    logic               lores;
  } draw_cmd_t;

  // bit-double a byte to 16 pixels
  function automatic logic [15:0] widen_byte(input logic [7:0] b);
    logic [15:0] v;
    v = {8'h00, b};
    v = ((v << 4) | v) & 16'h0F0F;
    v = ((v << 2) | v) & 16'h3333;
    v = ((v << 1) | v) & 16'h5555;
    return (v << 1) | v;
  endfunction

endpackage

@@ rtl/sxb_frame_mem.sv @@
// Frame store: one framebuffer line per entry, one write and one read port.
// Registered read data. No dependencies.
`timescale 1ns / 1ps

module sxb_frame_mem #(
  parameter int unsigned Width = 128,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sxb_row_alu.sv @@
// Sprite row datapath: places a row pattern at the cursor column, XORs it into
// the upper line and copies visited columns into the lower line. Uses sxb_pkg.
`timescale 1ns / 1ps

module sxb_row_alu #(
  parameter int unsigned FrameWidth = 128
) (
  input  sxb_pkg::draw_cmd_t    cmd_i,
  input  logic [FrameWidth-1:0] upper_i,
  input  logic [FrameWidth-1:0] lower_i,
  output logic [FrameWidth-1:0] new_upper_o,
  output logic [FrameWidth-1:0] new_lower_o,
  output logic                  hit_o
);
  import sxb_pkg::*;

  localparam int unsigned CW = $clog2(FrameWidth);

  logic [15:0]         pat;
  logic [15:0]         set16;
  logic [15:0]         vis16;
  logic [CW:0]         c8;
  logic                right_ok;
  logic [FrameWidth-1:0] setrow;
  logic [FrameWidth-1:0] visrow;

  always_comb begin
    logic [CW:0]   sum;
    logic [CW-1:0] off;
    logic          en;
    c8       = {1'b0, cmd_i.col[CW-1:0]} + (CW+1)'(8);
    right_ok = ~c8[CW];
    if (cmd_i.lores) begin
      pat = widen_byte(cmd_i.left_byte);
    end else begin
      pat = {cmd_i.left_byte, (cmd_i.wide && right_ok) ? cmd_i.right_byte : 8'h00};
    end
    for (int k = 0; k < 16; k++) begin
      sum      = {1'b0, cmd_i.col[CW-1:0]} + (CW+1)'(k);
      en       = cmd_i.wrap | ~sum[CW];
      set16[k] = pat[15-k] & en;
      vis16[k] = en & (cmd_i.left_byte != 8'h00);
    end
    for (int j = 0; j < FrameWidth; j++) begin
      off = CW'(j) - cmd_i.col[CW-1:0];
      if (off[CW-1:4] == '0) begin
        setrow[j] = set16[off[3:0]];
        visrow[j] = vis16[off[3:0]];
      end else begin
        setrow[j] = 1'b0;
        visrow[j] = 1'b0;
      end
    end
  end

  assign new_upper_o = upper_i ^ setrow;
  assign hit_o       = |(upper_i & setrow);
  assign new_lower_o = (visrow & new_upper_o) | (~visrow & lower_i);

endmodule

@@ rtl/sprite_xor_blitter_with_scroll_top.sv @@
// Channel   Dir  Width  Beat contents
// s_axis    in   40+3   sprite row or scroll command, opcode in tuser
// m_axis    out  8      collision flag and clip state after the command
// apb       in   3/32   wrap_sprite at 0x0, lores_mode at 0x4
//
// After reset a clear pass zeroes the frame store one line at a time; no beat
// is taken meanwhile. One command at a time: a row reads its line (and in lores
// the line below), XORs the pattern in and writes back; a row of a clipped sprite
// or an unused opcode only reports; a scroll copies the frame line by line through
// the single read and single write port of the frame store. A new beat is taken
// while the previous result waits on m_axis; a held result stalls the next one.
// Depends on sxb_pkg, sxb_frame_mem, sxb_row_alu and the defines header.
`timescale 1ns / 1ps

module sprite_xor_blitter_with_scroll_top #(
  parameter int unsigned FRAME_WIDTH  = 128,
  parameter int unsigned FRAME_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] x_pos, [15:8] y_pos, [23:16] left_byte, [31:24] right_byte,
  // [32] wide, [33] first_row, [37:34] scroll_amount, [39:38] zero
  input  logic [39:0] s_axis_tdata,
  // [2:0] opcode
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] flag_value, [5] clipped, [7:6] zero
  output logic [7:0]  m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sxb_pkg::*;
  `include "sprite_xor_blitter_with_scroll_top_defines.svh"

  localparam int unsigned RW = $clog2(FRAME_HEIGHT);
  localparam int unsigned CW = $clog2(FRAME_WIDTH);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DISP   = 4'd2;
  localparam logic [3:0] ST_RD1    = 4'd3;
  localparam logic [3:0] ST_RD2    = 4'd4;
  localparam logic [3:0] ST_CALC   = 4'd5;
  localparam logic [3:0] ST_WR_LO  = 4'd6;
  localparam logic [3:0] ST_SCROLL = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  localparam logic [RW-1:0] LastRow = RW'(FRAME_HEIGHT - 1);
  localparam logic [RW-1:0] PairRow = RW'(FRAME_HEIGHT - 2);

  logic [3:0]             state_q, state_d;
  logic [RW:0]            cnt_q, cnt_d;
  opcode_e                op_q, op_d;
  logic [7:0]             lb_q, lb_d, rb_q, rb_d;
  logic                   wide_q, wide_d;
  logic [3:0]             scroll_q, scroll_d;
  logic [RW-1:0]          row_q, row_d, lo_row_q, lo_row_d;
  logic [CW-1:0]          col_q, col_d;
  logic [4:0]             hit_q, hit_d;
  logic                   stop_q, stop_d;
  logic [FRAME_WIDTH-1:0] upper_q, upper_d, lower_q, lower_d, nlow_q, nlow_d;
  logic                   pend_q, pend_d, pzero_q, pzero_d;
  logic [RW-1:0]          pdst_q, pdst_d;
  logic                   wrap_q, lores_q;
  logic                   ovalid_q, ovalid_d;
  logic [5:0]             odata_q, odata_d;

  logic                   mem_we, mem_re;
  logic [RW-1:0]          mem_waddr, mem_raddr;
  logic [FRAME_WIDTH-1:0] mem_wdata, mem_rdata;

  draw_cmd_t              cmd;
  logic [FRAME_WIDTH-1:0] alu_upper, alu_lower;
  logic                   alu_hit;

  logic                   in_acc, cfg_wr;
  logic [RW-1:0]          dst;
  logic [RW:0]            src_sum;
  logic [RW-1:0]          src;
  logic                   src_ok;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {31'b0, lores_q} : {31'b0, wrap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q  <= 1'b0;
      lores_q <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        lores_q <= pwdata[0];
      end else begin
        wrap_q <= pwdata[0];
      end
    end
  end

  assign cmd.col        = ColMaxW'(col_q);
  assign cmd.left_byte  = lb_q;
  assign cmd.right_byte = rb_q;
  assign cmd.wide       = wide_q;
  assign cmd.wrap       = wrap_q;
  assign cmd.lores      = lores_q;

  sxb_row_alu #(
    .FrameWidth(FRAME_WIDTH)
  ) u_alu (
    .cmd_i      (cmd),
    .upper_i    (upper_q),
    .lower_i    (lower_q),
    .new_upper_o(alu_upper),
    .new_lower_o(alu_lower),
    .hit_o      (alu_hit)
  );

  sxb_frame_mem #(
    .Width(FRAME_WIDTH),
    .Depth(FRAME_HEIGHT)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // scroll source line for the current destination line
  always_comb begin
    dst = (op_q == OP_SCROLL_DOWN) ? ~cnt_q[RW-1:0] : cnt_q[RW-1:0];
    if (op_q == OP_SCROLL_UP) begin
      src_sum = {1'b0, dst} + (RW+1)'(scroll_q);
    end else if (op_q == OP_SCROLL_DOWN) begin
      src_sum = {1'b0, dst} - (RW+1)'(scroll_q);
    end else begin
      src_sum = {1'b0, dst};
    end
    src    = src_sum[RW-1:0];
    src_ok = ~src_sum[RW];
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    op_d      = op_q;
    lb_d      = lb_q;
    rb_d      = rb_q;
    wide_d    = wide_q;
    scroll_d  = scroll_q;
    row_d     = row_q;
    col_d     = col_q;
    lo_row_d  = lo_row_q;
    hit_d     = hit_q;
    stop_d    = stop_q;
    upper_d   = upper_q;
    lower_d   = lower_q;
    nlow_d    = nlow_q;
    pend_d    = 1'b0;
    pdst_d    = pdst_q;
    pzero_d   = pzero_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    odata_d   = odata_q;
    mem_we    = 1'b0;
    mem_waddr = row_q;
    mem_wdata = alu_upper;
    mem_re    = 1'b0;
    mem_raddr = row_q;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[RW-1:0];
        mem_wdata = '0;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q[RW-1:0] == LastRow) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          op_d     = opcode_e'(s_axis_tuser);
          lb_d     = s_axis_tdata[23:16];
          rb_d     = s_axis_tdata[31:24];
          wide_d   = s_axis_tdata[32];
          scroll_d = s_axis_tdata[37:34];
          if (opcode_e'(s_axis_tuser) == OP_SPRITE && s_axis_tdata[33]) begin
            hit_d  = '0;
            stop_d = 1'b0;
            if (lores_q) begin
              col_d = CW'({s_axis_tdata[7:0], 1'b0});
              row_d = RW'({s_axis_tdata[15:8], 1'b0});
            end else begin
              col_d = CW'(s_axis_tdata[7:0]);
              row_d = RW'(s_axis_tdata[15:8]);
            end
          end
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (op_q)
          OP_SPRITE: begin
            if (stop_q) begin
              state_d = ST_DONE;
            end else begin
              mem_re  = 1'b1;
              state_d = ST_RD1;
            end
          end
          OP_SCROLL_UP, OP_SCROLL_DOWN, OP_SCROLL_LEFT, OP_SCROLL_RIGHT: begin
            cnt_d   = '0;
            state_d = ST_SCROLL;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_RD1: begin
        upper_d = mem_rdata;
        if (lores_q) begin
          mem_re    = (row_q != LastRow);
          mem_raddr = row_q + 1'b1;
          state_d   = ST_RD2;
        end else begin
          state_d = ST_CALC;
        end
      end
      ST_RD2: begin
        lower_d = mem_rdata;
        state_d = ST_CALC;
      end
      ST_CALC: begin
        mem_we   = 1'b1;
        nlow_d   = alu_lower;
        lo_row_d = row_q + 1'b1;
        state_d  = ST_DONE;
        if (lores_q) begin
          if (alu_hit) begin
            hit_d = 5'd1;
          end
          if (!wrap_q && row_q == PairRow) begin
            stop_d = 1'b1;
          end else begin
            row_d = row_q + RW'(2);
          end
          if (row_q != LastRow) begin
            state_d = ST_WR_LO;
          end
        end else begin
          if (alu_hit && hit_q != FlagMax) begin
            hit_d = hit_q + 1'b1;
          end
          if (!wrap_q && row_q == LastRow) begin
            stop_d = 1'b1;
          end else begin
            row_d = row_q + 1'b1;
          end
        end
      end
      ST_WR_LO: begin
        mem_we    = 1'b1;
        mem_waddr = lo_row_q;
        mem_wdata = nlow_q;
        state_d   = ST_DONE;
      end
      ST_SCROLL: begin
        mem_we    = pend_q;
        mem_waddr = pdst_q;
        if (pzero_q) begin
          mem_wdata = '0;
        end else if (op_q == OP_SCROLL_LEFT) begin
          mem_wdata = mem_rdata >> ScrollCols;
        end else if (op_q == OP_SCROLL_RIGHT) begin
          mem_wdata = mem_rdata << ScrollCols;
        end else begin
          mem_wdata = mem_rdata;
        end
        if (!cnt_q[RW]) begin
          mem_re    = src_ok;
          mem_raddr = src;
          pend_d    = 1'b1;
          pdst_d    = dst;
          pzero_d   = !src_ok;
          cnt_d     = cnt_q + 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = {stop_q, hit_q};
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      cnt_q    <= '0;
      op_q     <= OP_SPRITE;
      row_q    <= '0;
      col_q    <= '0;
      hit_q    <= '0;
      stop_q   <= 1'b0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      op_q     <= op_d;
      row_q    <= row_d;
      col_q    <= col_d;
      hit_q    <= hit_d;
      stop_q   <= stop_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lb_q     <= lb_d;
    rb_q     <= rb_d;
    wide_q   <= wide_d;
    scroll_q <= scroll_d;
    lo_row_q <= lo_row_d;
    upper_q  <= upper_d;
    lower_q  <= lower_d;
    nlow_q   <= nlow_d;
    pdst_q   <= pdst_d;
    pzero_q  <= pzero_d;
    odata_q  <= odata_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {2'b00, odata_q};

  `SXB_ASSERT_IMP(a_no_rw_same_line, mem_we && mem_re, mem_waddr != mem_raddr,
    "frame store read and write hit the same line")
  `SXB_ASSERT_IMP(a_stop_from_row, $rose(stop_q), $past(state_q) == ST_CALC,
    "clip state set outside a row write")
  `SXB_ASSERT_IMP(a_no_accept_pending, in_acc, !pend_q,
    "beat taken with a scroll write pending")
  `SXB_ASSERT_NXT(a_one_at_a_time, in_acc, !s_axis_tready,
    "second beat taken before the first finished")

endmodule
